// ===== design/pst_pkg.sv =====
package pst_pkg;

  localparam int KEY_W = 48;
  localparam int SEQ_W = 32;
  localparam int SLOT_OUT_W = 4;

  typedef enum logic [1:0] {
    SEQ_OLD    = 2'd0,
    SEQ_NEXT   = 2'd1,
    SEQ_FUTURE = 2'd2
  } seq_class_t;

  // query walking down the cell row
  typedef struct packed {
    logic             vld;
    logic [KEY_W-1:0] key;   // {ip, port}
    logic [SEQ_W-1:0] seq;
    logic             hit;
    seq_class_t       hit_cls;
    logic             free;
  } query_t;

  // slot claim broadcast from the row end
  typedef struct packed {
    logic             en;
    logic [KEY_W-1:0] key;
    logic [SEQ_W-1:0] last;
  } claim_t;

  // 33-bit signed compare, last + 1 does not wrap
  function automatic seq_class_t classify(logic [SEQ_W-1:0] seq, logic [SEQ_W-1:0] last);
    logic signed [SEQ_W:0] s;
    logic signed [SEQ_W:0] l;
    logic signed [SEQ_W:0] lp1;
    seq_class_t            c;
    s   = {seq[SEQ_W-1], seq};
    l   = {last[SEQ_W-1], last};
    lp1 = l + {{SEQ_W{1'b0}}, 1'b1};
    if (s <= l) begin
      c = SEQ_OLD;
    end else if (s == lp1) begin
      c = SEQ_NEXT;
    end else begin
      c = SEQ_FUTURE;
    end
    return c;
  endfunction

endpackage

// ===== design/peer_sequence_tracker.sv =====
// The input transfer edge loads the first cell and the query moves one cell per
// cycle down the slot row. At the row end hit / claim / full is resolved
// combinationally into the tail register, then moves to the result register.
// One packet at a time: s_axis_tready is low from the input transfer until the tail result moves out.
// Reset (rst, synchronous) frees all slots and empties the pipeline.
module peer_sequence_tracker #(
  parameter int PEER_SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,  // src_ip[31:0], src_port[47:32], seq[79:48]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata   // slot_index[3:0], table_full[4], new_peer[5],
                                     // seq_class[7:6]
);
  import pst_pkg::*;

  localparam int IDX_W = (PEER_SLOTS > 1) ? $clog2(PEER_SLOTS) : 1;

  query_t           q    [PEER_SLOTS+1];
  logic [IDX_W-1:0] hidx [PEER_SLOTS+1];
  logic [IDX_W-1:0] fidx [PEER_SLOTS+1];

  claim_t           claim;
  logic [IDX_W-1:0] claim_idx;

  logic             busy;
  logic             in_xfer;
  logic             tail_valid;
  logic [IDX_W-1:0] tail_slot;
  logic             tail_full;
  logic             tail_new;
  seq_class_t       tail_cls;
  logic             tail_move;

  logic [IDX_W-1:0] end_slot;
  logic             end_full;
  logic             end_new;
  seq_class_t       end_cls;
  seq_class_t       fresh_cls;

  logic [IDX_W+SLOT_OUT_W-1:0] slot_ext;

  assign s_axis_tready = !busy;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign tail_move     = tail_valid && (!m_axis_tvalid || m_axis_tready);

  always_comb begin
    q[0].vld     = in_xfer;
    q[0].key     = {s_axis_tdata[31:0], s_axis_tdata[47:32]};
    q[0].seq     = s_axis_tdata[79:48];
    q[0].hit     = 1'b0;
    q[0].hit_cls = SEQ_OLD;
    q[0].free    = 1'b0;
    hidx[0]      = '0;
    fidx[0]      = '0;
  end

  for (genvar i = 0; i < PEER_SLOTS; i++) begin : g_cell
    pst_cell #(
      .IDX_W (IDX_W),
      .IDX   (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .q_in         (q[i]),
      .hit_idx_in   (hidx[i]),
      .free_idx_in  (fidx[i]),
      .q_out        (q[i+1]),
      .hit_idx_out  (hidx[i+1]),
      .free_idx_out (fidx[i+1]),
      .claim        (claim),
      .claim_idx    (claim_idx)
    );
  end

  // resolve at the row end; a fresh slot starts from last sequence 0
  always_comb begin
    fresh_cls  = classify(q[PEER_SLOTS].seq, '0);
    claim.en   = 1'b0;
    claim.key  = q[PEER_SLOTS].key;
    claim.last = (fresh_cls == SEQ_NEXT) ? q[PEER_SLOTS].seq : '0;
    claim_idx  = fidx[PEER_SLOTS];
    end_slot   = '0;
    end_full   = 1'b0;
    end_new    = 1'b0;
    end_cls    = SEQ_OLD;
    if (q[PEER_SLOTS].hit) begin
      end_slot = hidx[PEER_SLOTS];
      end_cls  = q[PEER_SLOTS].hit_cls;
    end else if (q[PEER_SLOTS].free) begin
      claim.en = q[PEER_SLOTS].vld;
      end_slot = fidx[PEER_SLOTS];
      end_new  = 1'b1;
      end_cls  = fresh_cls;
    end else begin
      end_full = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      tail_valid <= 1'b0;
    end else begin
      if (in_xfer) begin
        busy <= 1'b1;
      end else if (tail_move) begin
        busy <= 1'b0;
      end
      if (q[PEER_SLOTS].vld) begin
        tail_valid <= 1'b1;
      end else if (tail_move) begin
        tail_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q[PEER_SLOTS].vld) begin
      tail_slot <= end_slot;
      tail_full <= end_full;
      tail_new  <= end_new;
      tail_cls  <= end_cls;
    end
  end

  assign slot_ext = {{SLOT_OUT_W{1'b0}}, tail_slot};

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (tail_move) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (tail_move) begin
      m_axis_tdata <= {tail_cls, tail_new, tail_full, slot_ext[SLOT_OUT_W-1:0]};
    end
  end

endmodule

// ===== design/pst_cell.sv =====
module pst_cell #(
  parameter int IDX_W = 4,
  parameter int IDX   = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  pst_pkg::query_t     q_in,
  input  logic [IDX_W-1:0]    hit_idx_in,
  input  logic [IDX_W-1:0]    free_idx_in,
  output pst_pkg::query_t     q_out,
  output logic [IDX_W-1:0]    hit_idx_out,
  output logic [IDX_W-1:0]    free_idx_out,
  input  pst_pkg::claim_t     claim,
  input  logic [IDX_W-1:0]    claim_idx
);
  import pst_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic             used;
  logic [KEY_W-1:0] addr;
  logic [SEQ_W-1:0] last;

  seq_class_t cls;
  logic       take_hit;
  logic       take_free;
  query_t     q_next;

  always_comb begin
    cls       = classify(q_in.seq, last);
    take_hit  = q_in.vld && used && (addr == q_in.key) && !q_in.hit;
    take_free = q_in.vld && !used && !q_in.free;
    q_next    = q_in;
    if (take_hit) begin
      q_next.hit     = 1'b1;
      q_next.hit_cls = cls;
    end
    if (take_free) begin
      q_next.free = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_out.vld <= 1'b0;
    end else begin
      q_out <= q_next;
    end
    hit_idx_out  <= take_hit ? MY_IDX : hit_idx_in;
    free_idx_out <= take_free ? MY_IDX : free_idx_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= 1'b0;
    end else if (claim.en && claim_idx == MY_IDX) begin
      used <= 1'b1;
    end
  end

  // a hit updates in place; a claim comes only after a full miss pass
  always_ff @(posedge clk) begin
    if (claim.en && claim_idx == MY_IDX) begin
      addr <= claim.key;
      last <= claim.last;
    end else if (take_hit && cls == SEQ_NEXT) begin
      last <= q_in.seq;
    end
  end

endmodule

// ===== design/pst_checker.sv =====
module pst_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [7:0]  m_axis_tdata
);
  import pst_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tdata[4] |->
      m_axis_tdata[3:0] == 4'd0 && !m_axis_tdata[5] && m_axis_tdata[7:6] == SEQ_OLD)
    else $error("table full result carries slot, claim or class");

  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second packet taken while one is in the row");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid && s_axis_tready)
    else $error("block not idle after reset");

endmodule

bind peer_sequence_tracker pst_checker u_pst_checker (.*);

// ===== tb/sv/tb_top.sv =====
module tb_top;
  import pst_pkg::*;

  localparam int SLOTS = 16;
  localparam int N_RANDOM = 1100;

  typedef struct packed {
    logic [3:0] slot;
    logic       full;
    logic       newp;
    seq_class_t cls;
  } pkt_verdict_t;

  typedef struct packed {
    logic [31:0]  ip;
    logic [15:0]  port;
    logic [31:0]  sq;
    logic         typed;   // want holds a hand-written verdict
    pkt_verdict_t want;
  } stim_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;

  // shadow copy of the peer table
  bit          peer_live [SLOTS];
  logic [47:0] peer_key  [SLOTS];
  logic [31:0] peer_last [SLOTS];

  pkt_verdict_t pending_verdicts [$];
  int           n_err = 0;
  int           n_rcv = 0;
  bit           calm = 1'b0;

  // last + 1 only ever reaches the largest positive value after 2^31 in-order
  // transfers, so the no-wrap edge of the compare is out of reach here.
  stim_row_t dir_rows [24] = '{
    '{32'h0000_0000, 16'h0000, 32'h0000_0001, 1'b1, '{4'd0, 1'b0, 1'b1, SEQ_NEXT}},
    '{32'h0000_0000, 16'h0000, 32'h0000_0001, 1'b1, '{4'd0, 1'b0, 1'b0, SEQ_OLD}},
    '{32'h0000_0000, 16'h0000, 32'h8000_0000, 1'b1, '{4'd0, 1'b0, 1'b0, SEQ_OLD}},
    '{32'h0000_0000, 16'h0000, 32'h7FFF_FFFF, 1'b1, '{4'd0, 1'b0, 1'b0, SEQ_FUTURE}},
    '{32'h0000_0000, 16'h0000, 32'h0000_0002, 1'b1, '{4'd0, 1'b0, 1'b0, SEQ_NEXT}},
    '{32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0000, 1'b1, '{4'd1, 1'b0, 1'b1, SEQ_OLD}},
    '{32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, '{4'd1, 1'b0, 1'b0, SEQ_OLD}},
    '{32'h0000_0000, 16'hFFFF, 32'h0000_0001, 1'b1, '{4'd2, 1'b0, 1'b1, SEQ_NEXT}},
    '{32'hFFFF_FFFF, 16'h0000, 32'h0000_0002, 1'b1, '{4'd3, 1'b0, 1'b1, SEQ_FUTURE}},
    '{32'hC0A8_0004, 16'h1F90, 32'h0000_0001, 1'b0, '0},
    '{32'hC0A8_0005, 16'h1F91, 32'h0000_0000, 1'b0, '0},
    '{32'hC0A8_0006, 16'h1F92, 32'h5555_5555, 1'b0, '0},
    '{32'hC0A8_0007, 16'h1F93, 32'hAAAA_AAAA, 1'b0, '0},
    '{32'hC0A8_0008, 16'h1F94, 32'hFFFF_FFFF, 1'b0, '0},
    '{32'hC0A8_0009, 16'h1F95, 32'h0000_0001, 1'b0, '0},
    '{32'hC0A8_000A, 16'h1F96, 32'h0000_0002, 1'b0, '0},
    '{32'hC0A8_000B, 16'h1F97, 32'h8000_0000, 1'b0, '0},
    '{32'hC0A8_000C, 16'h1F98, 32'h0000_0001, 1'b0, '0},
    '{32'hC0A8_000D, 16'h1F99, 32'h7FFF_FFFF, 1'b0, '0},
    '{32'hC0A8_000E, 16'h1F9A, 32'h0000_0000, 1'b0, '0},
    '{32'hC0A8_000F, 16'h1F9B, 32'h0000_0001, 1'b0, '0},
    // table now full: unknown peer is refused, known peers still tracked
    '{32'h0A0A_0A0A, 16'h0050, 32'h0000_0001, 1'b1, '{4'd0, 1'b1, 1'b0, SEQ_OLD}},
    '{32'h0000_0000, 16'h0000, 32'h0000_0003, 1'b1, '{4'd0, 1'b0, 1'b0, SEQ_NEXT}},
    '{32'hFFFF_FFFF, 16'hFFFF, 32'h0000_0001, 1'b1, '{4'd1, 1'b0, 1'b0, SEQ_NEXT}}
  };

  peer_sequence_tracker #(.PEER_SLOTS(SLOTS)) uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #2 clk = ~clk;

  function automatic pkt_verdict_t track_packet(input logic [31:0] ip, input logic [15:0] port,
                                                input logic [31:0] sq);
    logic [47:0]        key;
    int                 hit;
    int                 free_s;
    int                 s;
    logic signed [32:0] sx;
    logic signed [32:0] lx;
    pkt_verdict_t       v;
    key = {ip, port};
    hit = -1;
    free_s = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (peer_live[i]) begin
        if (hit < 0 && peer_key[i] == key) hit = i;
      end else if (free_s < 0) begin
        free_s = i;
      end
    end
    if (hit < 0 && free_s < 0) begin
      v = '{4'd0, 1'b1, 1'b0, SEQ_OLD};
      return v;
    end
    v.full = 1'b0;
    v.newp = (hit < 0);
    s = (hit >= 0) ? hit : free_s;
    if (hit < 0) begin
      peer_live[s] = 1'b1;
      peer_key[s]  = key;
      peer_last[s] = '0;
    end
    v.slot = s[3:0];
    sx = {sq[31], sq};
    lx = {peer_last[s][31], peer_last[s]};
    if (sx <= lx) begin
      v.cls = SEQ_OLD;
    end else if (sx == lx + 33'sd1) begin
      v.cls = SEQ_NEXT;
      peer_last[s] = sq;
    end else begin
      v.cls = SEQ_FUTURE;
    end
    return v;
  endfunction

  task automatic send_packet(input logic [31:0] ip, input logic [15:0] port,
                             input logic [31:0] sq, input logic typed,
                             input pkt_verdict_t want);
    pkt_verdict_t v;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {sq, port, ip};
    do @(posedge clk); while (s_axis_tready !== 1'b1);
    v = track_packet(ip, port, sq);
    pending_verdicts.push_back(typed ? want : v);
  endtask

  task automatic sender_gap();
    int n;
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) n = 0;
    else if (r < 92) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 60);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  function automatic void check_result(input logic [7:0] d);
    pkt_verdict_t exp_v;
    pkt_verdict_t got;
    got = '{d[3:0], d[4], d[5], seq_class_t'(d[7:6])};
    n_rcv++;
    if (pending_verdicts.size() == 0) begin
      $display("%0t: result with nothing expected, got %h", $time, d);
      n_err++;
      return;
    end
    exp_v = pending_verdicts.pop_front();
    if (got.slot !== exp_v.slot) begin
      $display("%0t: slot_index expected %0d got %0d", $time, exp_v.slot, got.slot);
      n_err++;
    end
    if (got.full !== exp_v.full) begin
      $display("%0t: table_full expected %b got %b", $time, exp_v.full, got.full);
      n_err++;
    end
    if (got.newp !== exp_v.newp) begin
      $display("%0t: new_peer expected %b got %b", $time, exp_v.newp, got.newp);
      n_err++;
    end
    if (got.cls !== exp_v.cls) begin
      $display("%0t: seq_class expected %0d got %0d", $time, exp_v.cls, got.cls);
      n_err++;
    end
  endfunction

  // result side: random stalls, one long hold-off to stall the sender
  initial begin
    int  stall;
    int  r;
    bit  held;
    stall = 0;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1) check_result(m_axis_tdata);
      if (!held && n_rcv == 200) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (400) @(posedge clk);
      end else if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        if (!calm) begin
          r = $urandom_range(0, 99);
          if (r < 25) stall = $urandom_range(1, 3);
          else if (r < 29) stall = $urandom_range(10, 60);
        end
      end
    end
  end

  initial begin
    int           s;
    logic [31:0]  ip;
    logic [15:0]  port;
    logic [31:0]  sq;
    pkt_verdict_t none;
    none = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[k]) begin
      send_packet(dir_rows[k].ip, dir_rows[k].port, dir_rows[k].sq, dir_rows[k].typed,
                  dir_rows[k].want);
      sender_gap();
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      calm = (i >= 400 && i < 550);
      if (i == 700) begin
        // drain everything before going on
        s_axis_tvalid <= 1'b0;
        do @(posedge clk); while (pending_verdicts.size() != 0);
      end
      if ($urandom_range(0, 9) == 0) begin
        // most likely an unknown peer, refused by the full table
        ip   = $urandom;
        port = 16'($urandom);
        sq   = $urandom;
      end else begin
        s = $urandom_range(0, SLOTS - 1);
        {ip, port} = peer_key[s];
        case ($urandom_range(0, 9))
          6:       sq = peer_last[s];
          7:       sq = peer_last[s] - $urandom_range(1, 1000);
          8:       sq = peer_last[s] + $urandom_range(2, 1000);
          9:       sq = $urandom;
          default: sq = peer_last[s] + 32'd1;
        endcase
      end
      send_packet(ip, port, sq, 1'b0, none);
      sender_gap();
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0);
    repeat (40) @(posedge clk);
    if (n_err == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Verification failed");
    $finish;
  end

endmodule
